### rtl/assert_macros.svh
// Assertion helpers used by homography_point_mapper.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HPM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define HPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HPM_ASSERT(lbl, clk, rst, prop)
`define HPM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/hpm_pkg.sv
package hpm_pkg;

   localparam int COEF_WIDTH_DEF = 32;
   localparam int PIX_W          = 48;
   localparam int QUOT_W         = 33;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int FIELD_W        = 31;

   localparam logic [CSR_ADDR_W-1:0] REG_H0_H1  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_H2_H3  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_H4_H5  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_H6_H7  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_H8     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_LENGTH = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_MARGIN = 3'd7;

   localparam logic [63:0] RST_H0_H1 = 64'd16777216;
   localparam logic [63:0] RST_H2_H3 = 64'd0;
   localparam logic [63:0] RST_H4_H5 = 64'd16777216;
   localparam logic [63:0] RST_H6_H7 = 64'd0;
   localparam logic [31:0] RST_H8    = 32'd16777216;
   localparam logic [FIELD_W-1:0] RST_LENGTH = 31'd3538944;
   localparam logic [FIELD_W-1:0] RST_WIDTH  = 31'd1769472;
   localparam logic [FIELD_W-1:0] RST_MARGIN = 31'd131072;

   // Denominator magnitudes below this count as degenerate.
   localparam int DEN_EPS_RAW = 3;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic deg;
      logic ovf_x;
      logic ovf_y;
   } div_side_type;

endpackage

### rtl/homography_point_mapper.sv
// Maps one image point or detection box bottom-center per beat to field
// coordinates through a 3x3 fixed-point homography, with six front stages for
// pixel forming, multiplies and sums, a 33-step restoring divider with one step
// per stage, and two output stages. One beat is accepted every cycle, but the
// whole pipeline holds while a result beat waits on rsp_tready. The user must
// write coefficient and field registers through the csr port while no request
// is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module homography_point_mapper #(
   parameter int COEF_WIDTH = hpm_pkg::COEF_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coord_x[31:0], coord_y[63:32], box_width[81:64], box_height[99:82],
   // image_width[113:100], image_height[127:114]
   input  logic [127:0] req_tdata,
   // operation[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // field_x[31:0], field_y[63:32]
   output logic [63:0]  rsp_tdata,
   // mapped_valid[0], saturated[1], inside_field[2]
   output logic [2:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [hpm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [hpm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW     = COEF_WIDTH;
   localparam int NUM_W  = CW + hpm_pkg::PIX_W + 2;
   localparam int REM_W  = NUM_W + 33;
   localparam int QW     = hpm_pkg::QUOT_W;
   localparam int FW     = hpm_pkg::FIELD_W;

   logic [63:0] h01_ff, h23_ff, h45_ff, h67_ff;
   logic [31:0] h8_ff;
   logic [FW-1:0] len_ff, wid_ff, mar_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h01_ff <= hpm_pkg::RST_H0_H1;
         h23_ff <= hpm_pkg::RST_H2_H3;
         h45_ff <= hpm_pkg::RST_H4_H5;
         h67_ff <= hpm_pkg::RST_H6_H7;
         h8_ff  <= hpm_pkg::RST_H8;
         len_ff <= hpm_pkg::RST_LENGTH;
         wid_ff <= hpm_pkg::RST_WIDTH;
         mar_ff <= hpm_pkg::RST_MARGIN;
      end else if (csr_we) begin
         unique case (csr_addr)
            hpm_pkg::REG_H0_H1:  h01_ff <= csr_wdata;
            hpm_pkg::REG_H2_H3:  h23_ff <= csr_wdata;
            hpm_pkg::REG_H4_H5:  h45_ff <= csr_wdata;
            hpm_pkg::REG_H6_H7:  h67_ff <= csr_wdata;
            hpm_pkg::REG_H8:     h8_ff  <= csr_wdata[31:0];
            hpm_pkg::REG_LENGTH: len_ff <= csr_wdata[FW-1:0];
            hpm_pkg::REG_WIDTH:  wid_ff <= csr_wdata[FW-1:0];
            hpm_pkg::REG_MARGIN: mar_ff <= csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   logic signed [CW-1:0] coef [9];

   always_comb begin
      coef[0] = $signed(h01_ff[CW-1:0]);
      coef[1] = $signed(h01_ff[32+CW-1:32]);
      coef[2] = $signed(h23_ff[CW-1:0]);
      coef[3] = $signed(h23_ff[32+CW-1:32]);
      coef[4] = $signed(h45_ff[CW-1:0]);
      coef[5] = $signed(h45_ff[32+CW-1:32]);
      coef[6] = $signed(h67_ff[CW-1:0]);
      coef[7] = $signed(h67_ff[32+CW-1:32]);
      coef[8] = $signed(h8_ff[CW-1:0]);
   end

   logic pipe_en;
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;

   logic [QW:0]     div_v;
   logic [NUM_W-1:0] div_d  [QW+1];
   logic [REM_W-1:0] div_rx [QW+1];
   logic [REM_W-1:0] div_ry [QW+1];
   logic [QW-1:0]   div_qx [QW+1];
   logic [QW-1:0]   div_qy [QW+1];
   hpm_pkg::div_side_type div_side [QW+1];

   hpm_front #(.CW(CW), .NUM_W(NUM_W), .REM_W(REM_W)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_v     (req_tvalid),
      .op       (req_tuser),
      .cx       (req_tdata[31:0]),
      .cy       (req_tdata[63:32]),
      .bw       (req_tdata[81:64]),
      .bh       (req_tdata[99:82]),
      .iw       (req_tdata[113:100]),
      .ih       (req_tdata[127:114]),
      .coef     (coef),
      .out_v    (div_v[0]),
      .out_d    (div_d[0]),
      .out_rx   (div_rx[0]),
      .out_ry   (div_ry[0]),
      .out_side (div_side[0])
   );

   assign div_qx[0] = '0;
   assign div_qy[0] = '0;

   // Quotient bits come out most significant first, one per stage.
   for (genvar i = 0; i < QW; i++) begin : g_div
      hpm_div_step #(.DW(NUM_W), .W(REM_W), .SH(QW - 1 - i)) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .in_v     (div_v[i]),
         .in_d     (div_d[i]),
         .in_rx    (div_rx[i]),
         .in_ry    (div_ry[i]),
         .in_qx    (div_qx[i]),
         .in_qy    (div_qy[i]),
         .in_side  (div_side[i]),
         .out_v    (div_v[i+1]),
         .out_d    (div_d[i+1]),
         .out_rx   (div_rx[i+1]),
         .out_ry   (div_ry[i+1]),
         .out_qx   (div_qx[i+1]),
         .out_qy   (div_qy[i+1]),
         .out_side (div_side[i+1])
      );
   end

   hpm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .en           (pipe_en),
      .in_v         (div_v[QW]),
      .qx           (div_qx[QW]),
      .qy           (div_qy[QW]),
      .side         (div_side[QW]),
      .field_length (len_ff),
      .field_width  (wid_ff),
      .field_margin (mar_ff),
      .out_v        (rsp_tvalid),
      .field_x      (rsp_tdata[31:0]),
      .field_y      (rsp_tdata[63:32]),
      .mapped_valid (rsp_tuser[0]),
      .saturated    (rsp_tuser[1]),
      .inside_field (rsp_tuser[2])
   );

   `HPM_ASSERT(a_inside_clean, clock, reset, !(rsp_tvalid && rsp_tuser[2]) || (rsp_tuser[0] && !rsp_tuser[1]))
   `HPM_ASSERT(a_degen_zero, clock, reset, !(rsp_tvalid && !rsp_tuser[0]) || (rsp_tdata == 64'd0 && !rsp_tuser[1]))
   `HPM_ASSERT_NEXT(a_stall_holds, clock, reset, !pipe_en, $stable(div_v))

endmodule

### rtl/hpm_front.sv
module hpm_front #(
   parameter int CW    = hpm_pkg::COEF_WIDTH_DEF,
   parameter int NUM_W = CW + hpm_pkg::PIX_W + 2,
   parameter int REM_W = NUM_W + 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_v,
   input  logic                       op,
   input  logic [31:0]                cx,
   input  logic [31:0]                cy,
   input  logic [17:0]                bw,
   input  logic [17:0]                bh,
   input  logic [13:0]                iw,
   input  logic [13:0]                ih,
   input  logic signed [CW-1:0]       coef [9],
   output logic                       out_v,
   output logic [NUM_W-1:0]           out_d,
   output logic [REM_W-1:0]           out_rx,
   output logic [REM_W-1:0]           out_ry,
   output hpm_pkg::div_side_type      out_side
);

   localparam int PW     = hpm_pkg::PIX_W;
   localparam int HALF   = PW / 2;
   localparam int PROD_W = CW + PW;
   localparam int PH_W   = CW + HALF;
   localparam int PL_W   = CW + HALF + 1;
   localparam int OFF_W  = CW + 17;

   logic [5:0] v_ff;

   // Stage 1: pixel in signed Q.17.
   logic signed [33:0] sx;
   logic signed [48:0] pxm;
   logic signed [32:0] sy;
   logic signed [47:0] pym;
   logic signed [PW-1:0] px_in, py_in, px_ff, py_ff;

   always_comb begin
      sx  = $signed({cx[31], cx, 1'b0}) + $signed({16'd0, bw});
      pxm = sx * $signed({1'b0, iw});
      sy  = $signed({cy[31], cy}) + $signed({15'd0, bh});
      pym = sy * $signed({1'b0, ih});
      if (op) begin
         px_in = pxm[PW-1:0];
         py_in = {pym[PW-2:0], 1'b0};
      end else begin
         px_in = {{(PW-33){cx[31]}}, cx, 1'b0};
         py_in = {{(PW-33){cy[31]}}, cy, 1'b0};
      end
   end

   // Stage 2: each coefficient times the upper and lower pixel halves.
   logic signed [PH_W-1:0]  ph_ff [6];
   logic signed [PL_W-1:0]  pl_ff [6];
   logic signed [OFF_W-1:0] off_ff [3];
   logic signed [CW-1:0]    pc [6];
   logic signed [PW-1:0]    pp [6];

   always_comb begin
      pc[0] = coef[0]; pp[0] = px_ff;
      pc[1] = coef[1]; pp[1] = py_ff;
      pc[2] = coef[3]; pp[2] = px_ff;
      pc[3] = coef[4]; pp[3] = py_ff;
      pc[4] = coef[6]; pp[4] = px_ff;
      pc[5] = coef[7]; pp[5] = py_ff;
   end

   // Stage 3: whole products.
   logic signed [PROD_W-1:0] prod_ff [6];
   // Stage 4: numerators and denominator.
   logic signed [NUM_W-1:0] nx_ff, ny_ff, dn_ff;
   // Stage 5: magnitudes and signs.
   logic [NUM_W-1:0] mx_ff, my_ff, md_ff;
   logic sx_ff, sy_ff, sd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         for (int k = 0; k < 6; k++) begin
            ph_ff[k] <= pc[k] * $signed(pp[k][PW-1:HALF]);
            pl_ff[k] <= pc[k] * $signed({1'b0, pp[k][HALF-1:0]});
            prod_ff[k] <= ($signed(PROD_W'(ph_ff[k])) <<< HALF) + PROD_W'(pl_ff[k]);
         end
         off_ff[0] <= $signed(OFF_W'(coef[2])) <<< 17;
         off_ff[1] <= $signed(OFF_W'(coef[5])) <<< 17;
         off_ff[2] <= $signed(OFF_W'(coef[8])) <<< 17;
         nx_ff <= NUM_W'(prod_ff[0]) + NUM_W'(prod_ff[1]) + NUM_W'(off_ff[0]);
         ny_ff <= NUM_W'(prod_ff[2]) + NUM_W'(prod_ff[3]) + NUM_W'(off_ff[1]);
         dn_ff <= NUM_W'(prod_ff[4]) + NUM_W'(prod_ff[5]) + NUM_W'(off_ff[2]);
         sx_ff <= nx_ff[NUM_W-1];
         sy_ff <= ny_ff[NUM_W-1];
         sd_ff <= dn_ff[NUM_W-1];
         mx_ff <= nx_ff[NUM_W-1] ? NUM_W'(-nx_ff) : NUM_W'(nx_ff);
         my_ff <= ny_ff[NUM_W-1] ? NUM_W'(-ny_ff) : NUM_W'(ny_ff);
         md_ff <= dn_ff[NUM_W-1] ? NUM_W'(-dn_ff) : NUM_W'(dn_ff);
         // Stage 6: a quotient of 2^33 or more cannot come out of the divider.
         out_d  <= md_ff;
         out_rx <= REM_W'(mx_ff) << 16;
         out_ry <= REM_W'(my_ff) << 16;
         out_side.neg_x <= sx_ff ^ sd_ff;
         out_side.neg_y <= sy_ff ^ sd_ff;
         out_side.deg   <= md_ff < NUM_W'(hpm_pkg::DEN_EPS_RAW);
         out_side.ovf_x <= (NUM_W+17)'(mx_ff) >= ((NUM_W+17)'(md_ff) << 17);
         out_side.ovf_y <= (NUM_W+17)'(my_ff) >= ((NUM_W+17)'(md_ff) << 17);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_v};
      end
   end

   assign out_v = v_ff[5];

endmodule

### rtl/hpm_div_step.sv
module hpm_div_step #(
   parameter int DW = 82,
   parameter int W  = 115,
   parameter int SH = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_v,
   input  logic [DW-1:0]         in_d,
   input  logic [W-1:0]          in_rx,
   input  logic [W-1:0]          in_ry,
   input  logic [hpm_pkg::QUOT_W-1:0] in_qx,
   input  logic [hpm_pkg::QUOT_W-1:0] in_qy,
   input  hpm_pkg::div_side_type in_side,
   output logic                  out_v,
   output logic [DW-1:0]         out_d,
   output logic [W-1:0]          out_rx,
   output logic [W-1:0]          out_ry,
   output logic [hpm_pkg::QUOT_W-1:0] out_qx,
   output logic [hpm_pkg::QUOT_W-1:0] out_qy,
   output hpm_pkg::div_side_type out_side
);

   localparam int QW = hpm_pkg::QUOT_W;

   logic [W:0] dsh, tx, ty;

   always_comb begin
      dsh = (W+1)'(in_d) << SH;
      tx  = {1'b0, in_rx} - dsh;
      ty  = {1'b0, in_ry} - dsh;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_d    <= in_d;
         out_side <= in_side;
         out_rx   <= tx[W] ? in_rx : tx[W-1:0];
         out_ry   <= ty[W] ? in_ry : ty[W-1:0];
         out_qx   <= {in_qx[QW-2:0], ~tx[W]};
         out_qy   <= {in_qy[QW-2:0], ~ty[W]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v <= 1'b0;
      end else if (en) begin
         out_v <= in_v;
      end
   end

endmodule

### rtl/hpm_back.sv
module hpm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_v,
   input  logic [hpm_pkg::QUOT_W-1:0] qx,
   input  logic [hpm_pkg::QUOT_W-1:0] qy,
   input  hpm_pkg::div_side_type side,
   input  logic [hpm_pkg::FIELD_W-1:0] field_length,
   input  logic [hpm_pkg::FIELD_W-1:0] field_width,
   input  logic [hpm_pkg::FIELD_W-1:0] field_margin,
   output logic                  out_v,
   output logic [31:0]           field_x,
   output logic [31:0]           field_y,
   output logic                  mapped_valid,
   output logic                  saturated,
   output logic                  inside_field
);

   localparam int QW = hpm_pkg::QUOT_W;

   logic [QW-1:0] lim_x, lim_y, mag_x, mag_y;
   logic sat_x, sat_y;
   logic [31:0] fx_in, fy_in, fx_ff, fy_ff;
   logic val_in, sat_in, val_ff, sat_ff, v_ff;

   always_comb begin
      lim_x = side.neg_x ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      lim_y = side.neg_y ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      sat_x = side.ovf_x || (qx > lim_x);
      sat_y = side.ovf_y || (qy > lim_y);
      mag_x = sat_x ? lim_x : qx;
      mag_y = sat_y ? lim_y : qy;
      val_in = !side.deg;
      if (side.deg) begin
         fx_in  = '0;
         fy_in  = '0;
         sat_in = 1'b0;
      end else begin
         fx_in  = side.neg_x ? -mag_x[31:0] : mag_x[31:0];
         fy_in  = side.neg_y ? -mag_y[31:0] : mag_y[31:0];
         sat_in = sat_x || sat_y;
      end
   end

   logic signed [33:0] m34, lo34, hx34, hy34, fx34, fy34;
   logic ins_in;

   always_comb begin
      m34  = $signed({3'd0, field_margin});
      lo34 = -m34;
      hx34 = $signed({3'd0, field_length}) + m34;
      hy34 = $signed({3'd0, field_width}) + m34;
      fx34 = $signed({{2{fx_ff[31]}}, fx_ff});
      fy34 = $signed({{2{fy_ff[31]}}, fy_ff});
      ins_in = val_ff && !sat_ff && (fx34 >= lo34) && (fx34 <= hx34) &&
               (fy34 >= lo34) && (fy34 <= hy34);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         val_ff       <= val_in;
         sat_ff       <= sat_in;
         field_x      <= fx_ff;
         field_y      <= fy_ff;
         mapped_valid <= val_ff;
         saturated    <= sat_ff;
         inside_field <= ins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         out_v <= 1'b0;
      end else if (en) begin
         v_ff  <= in_v;
         out_v <= v_ff;
      end
   end

endmodule

### sim/homography_point_mapper_test.sv
`timescale 1ns / 100ps

module homography_point_mapper_test;

   localparam int PIPE_LATENCY = 41;
   localparam int RANDOM_BEATS = 800;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] fx;
      logic [31:0] fy;
      logic        ok;
      logic        sat;
      logic        on_field;
   } mapped_point_type;

   typedef struct {
      logic        op;
      logic [31:0] cx;
      logic [31:0] cy;
      logic [17:0] bw;
      logic [17:0] bh;
      logic [13:0] iw;
      logic [13:0] ih;
      logic        known;   // expected result typed into the row
      mapped_point_type res;
   } point_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_we;
   logic [hpm_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [hpm_pkg::CSR_DATA_W-1:0] csr_wdata;

   homography_point_mapper dut (.*);

   // Shadow copy of the register file.
   logic [63:0] sh_h01, sh_h23, sh_h45, sh_h67;
   logic [31:0] sh_h8;
   logic [30:0] sh_len, sh_wid, sh_mar;

   mapped_point_type expected_points[$];
   int     mismatches;
   longint cycle_count;
   bit     hold_rsp;   // long receiver hold-off request

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("homography_point_mapper: mismatch");
         $finish;
      end
   end

   function automatic logic signed [127:0] coef_of(logic [31:0] half);
      return 128'(signed'(half));
   endfunction

   // Truncating divide of Q.41 by Q.41 into Q.16 with clamping to 32 bits.
   function automatic logic [31:0] divide_clamped(logic signed [127:0] num,
                                                  logic signed [127:0] den,
                                                  inout logic sat);
      logic signed [127:0] q;
      q = (num <<< 16) / den;
      if (q > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (q < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return q[31:0];
   endfunction

   function automatic mapped_point_type map_point(point_row_type r);
      logic signed [127:0] px, py, nx, ny, dn, m, hi_x, hi_y, fx, fy;
      mapped_point_type o;
      o = '0;
      if (r.op) begin
         px = (2 * 128'(signed'(r.cx)) + 128'(r.bw)) * 128'(r.iw);
         py = 2 * (128'(signed'(r.cy)) + 128'(r.bh)) * 128'(r.ih);
      end else begin
         px = 2 * 128'(signed'(r.cx));
         py = 2 * 128'(signed'(r.cy));
      end
      nx = coef_of(sh_h01[31:0]) * px + coef_of(sh_h01[63:32]) * py
           + coef_of(sh_h23[31:0]) * 128'sd131072;
      ny = coef_of(sh_h23[63:32]) * px + coef_of(sh_h45[31:0]) * py
           + coef_of(sh_h45[63:32]) * 128'sd131072;
      dn = coef_of(sh_h67[31:0]) * px + coef_of(sh_h67[63:32]) * py
           + coef_of(sh_h8) * 128'sd131072;
      if (dn < hpm_pkg::DEN_EPS_RAW && dn > -hpm_pkg::DEN_EPS_RAW) return o;
      o.ok = 1'b1;
      o.fx = divide_clamped(nx, dn, o.sat);
      o.fy = divide_clamped(ny, dn, o.sat);
      // Bounds are held in signed variables so that every compare stays signed.
      m    = 128'(sh_mar);
      hi_x = 128'(sh_len);
      hi_x = hi_x + m;
      hi_y = 128'(sh_wid);
      hi_y = hi_y + m;
      fx   = 128'(signed'(o.fx));
      fy   = 128'(signed'(o.fy));
      o.on_field = !o.sat && fx >= -m && fx <= hi_x && fy >= -m && fy <= hi_y;
      return o;
   endfunction

   task automatic write_reg(logic [hpm_pkg::CSR_ADDR_W-1:0] idx, logic [63:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         hpm_pkg::REG_H0_H1:  sh_h01 = val;
         hpm_pkg::REG_H2_H3:  sh_h23 = val;
         hpm_pkg::REG_H4_H5:  sh_h45 = val;
         hpm_pkg::REG_H6_H7:  sh_h67 = val;
         hpm_pkg::REG_H8:     sh_h8  = val[31:0];
         hpm_pkg::REG_LENGTH: sh_len = val[30:0];
         hpm_pkg::REG_WIDTH:  sh_wid = val[30:0];
         hpm_pkg::REG_MARGIN: sh_mar = val[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      if (n != 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_point(point_row_type r, bit pause);
      mapped_point_type e;
      e = r.known ? r.res : map_point(r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {r.ih, r.iw, r.bh, r.bw, r.cy, r.cx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_points = {expected_points, e};
      if (pause) gap();
   endtask

   function automatic point_row_type random_point();
      point_row_type r;
      int k;
      r = '{default: '0};
      r.op = 1'($urandom_range(0, 1));
      k = $urandom_range(0, 9);
      if (r.op) begin
         // Box fractions mostly inside [0, 1].
         r.cx = (k == 0) ? $urandom() : $urandom_range(0, 65536);
         r.cy = (k == 1) ? $urandom() : $urandom_range(0, 65536);
         r.bw = 18'($urandom_range(0, 131072));
         r.bh = 18'($urandom_range(0, 131072));
         r.iw = (k == 2) ? 14'($urandom_range(0, 16383)) : 14'($urandom_range(1, 8192));
         r.ih = (k == 3) ? 14'($urandom_range(0, 16383)) : 14'($urandom_range(1, 8192));
      end else begin
         r.cx = (k < 2) ? $urandom() : $urandom_range(0, 4000 << 16);
         r.cy = (k < 2) ? $urandom() : $urandom_range(0, 3000 << 16);
         r.bw = 18'($urandom());
         r.bh = 18'($urandom());
         r.iw = 14'($urandom());
         r.ih = 14'($urandom());
      end
      return r;
   endfunction

   // Plausible homography: scale to feet with a mild perspective term; fully random when wild.
   task automatic random_setting(bit wild);
      logic [31:0] h[9];
      if (wild) begin
         foreach (h[i]) h[i] = $urandom();
      end else begin
         h[0] = $urandom_range(0, 1 << 20);
         h[1] = $urandom_range(0, 1 << 18) - (1 << 17);
         h[2] = $urandom_range(0, 1 << 26) - (1 << 25);
         h[3] = $urandom_range(0, 1 << 18) - (1 << 17);
         h[4] = $urandom_range(0, 1 << 20);
         h[5] = $urandom_range(0, 1 << 26) - (1 << 25);
         h[6] = $urandom_range(0, 1 << 10) - (1 << 9);
         h[7] = $urandom_range(0, 1 << 10) - (1 << 9);
         h[8] = $urandom_range(1 << 23, 1 << 25);
      end
      write_reg(hpm_pkg::REG_H0_H1, {h[1], h[0]});
      write_reg(hpm_pkg::REG_H2_H3, {h[3], h[2]});
      write_reg(hpm_pkg::REG_H4_H5, {h[5], h[4]});
      write_reg(hpm_pkg::REG_H6_H7, {h[7], h[6]});
      write_reg(hpm_pkg::REG_H8, {$urandom(), h[8]});
      write_reg(hpm_pkg::REG_LENGTH, {$urandom(), $urandom()});
      write_reg(hpm_pkg::REG_WIDTH, 64'($urandom_range(0, 1 << 24)));
      write_reg(hpm_pkg::REG_MARGIN, 64'($urandom_range(0, 1 << 18)));
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
         if ($urandom_range(0, 1) == 0) n = 0;
         rsp_tready <= (n == 0);
         repeat (n == 0 ? 1 : n) @(posedge clock);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      mapped_point_type e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0], rsp_tuser[1], rsp_tuser[2]};
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", a);
         end else begin
            e = expected_points.pop_front();
            if (e !== a) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("x exp %h got %h, y exp %h got %h, flags exp %b%b%b got %b%b%b",
                           e.fx, a.fx, e.fy, a.fy, e.ok, e.sat, e.on_field,
                           a.ok, a.sat, a.on_field);
            end
         end
      end
   end

   point_row_type directed[$];

   initial begin
      point_row_type r;
      int tmo;
      cycle_count = 0;
      mismatches  = 0;
      hold_rsp    = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      csr_we      <= 1'b0;
      csr_addr    <= '0;
      csr_wdata   <= '0;
      sh_h01 = hpm_pkg::RST_H0_H1; sh_h23 = hpm_pkg::RST_H2_H3;
      sh_h45 = hpm_pkg::RST_H4_H5; sh_h67 = hpm_pkg::RST_H6_H7;
      sh_h8  = hpm_pkg::RST_H8;    sh_len = hpm_pkg::RST_LENGTH;
      sh_wid = hpm_pkg::RST_WIDTH; sh_mar = hpm_pkg::RST_MARGIN;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity after reset: field point equals the pixel.
      r = '{default: '0};
      r.known = 1'b1;
      r.cx = 32'h000a0000; r.cy = 32'h00050000;
      r.res = '{fx: 32'h000a0000, fy: 32'h00050000, ok: 1'b1, sat: 1'b0, on_field: 1'b1};
      directed = {directed, r};
      r.cx = 32'h7fffffff; r.cy = 32'h80000000;
      r.res = '{fx: 32'h7fffffff, fy: 32'h80000000, ok: 1'b1, sat: 1'b0, on_field: 1'b0};
      directed = {directed, r};
      r.cx = 32'hfffe0000; r.cy = 32'h0;   // exactly on the margin
      r.res = '{fx: 32'hfffe0000, fy: 32'h0, ok: 1'b1, sat: 1'b0, on_field: 1'b1};
      directed = {directed, r};
      r.cx = 32'hfffdffff;
      r.res = '{fx: 32'hfffdffff, fy: 32'h0, ok: 1'b1, sat: 1'b0, on_field: 1'b0};
      directed = {directed, r};
      r.known = 1'b0;
      r.cx = 32'h0; r.cy = 32'h0; r.bw = '1; r.bh = '1; r.iw = '1; r.ih = '1;
      directed = {directed, r};
      // Box mode extremes and zero image size.
      r.op = 1'b1;
      r.cx = 32'h8000; r.cy = 32'h4000; r.bw = 18'h20000; r.bh = 18'h20000;
      r.iw = 14'd8192; r.ih = 14'd8192;
      directed = {directed, r};
      r.cx = 32'h0; r.cy = 32'h0; r.bw = 18'h10000; r.bh = 18'h1; r.iw = 14'd0; r.ih = 14'd1;
      directed = {directed, r};
      r.iw = 14'd1; r.ih = 14'd0; r.bw = 18'h0; r.bh = 18'h0;
      directed = {directed, r};
      r.cx = 32'h7fffffff; r.cy = 32'h80000000; r.bw = 18'h3ffff; r.bh = 18'h3ffff;
      r.iw = 14'h3fff; r.ih = 14'h3fff;
      directed = {directed, r};
      foreach (directed[i]) send_point(directed[i], 1'b0);
      wait_drained();

      // Degenerate denominator with h8 = 0, then overflow with a tiny h8.
      write_reg(hpm_pkg::REG_H8, 64'h0);
      r = '{default: '0};
      r.known = 1'b1;
      r.res = '0;
      send_point(r, 1'b0);
      wait_drained();
      write_reg(hpm_pkg::REG_H6_H7, 64'h1);
      r.cx = 32'h1; r.known = 1'b0;   // D = 2 still degenerate
      send_point(r, 1'b0);
      r.cx = 32'hffffffff;
      send_point(r, 1'b0);
      r.cx = 32'h00010000; r.cy = 32'h00010000;
      send_point(r, 1'b0);
      r.cx = 32'hffff0000;
      send_point(r, 1'b0);
      wait_drained();
      write_reg(hpm_pkg::REG_H6_H7, 64'h0);
      write_reg(hpm_pkg::REG_H8, 64'h1);
      r = '{default: '0};
      r.cx = 32'h00640000; r.cy = 32'hff9c0000;
      send_point(r, 1'b0);
      wait_drained();
      // Widest coefficients and field limits.
      write_reg(hpm_pkg::REG_H0_H1, 64'h80000000_7fffffff);
      write_reg(hpm_pkg::REG_H2_H3, 64'h7fffffff_80000000);
      write_reg(hpm_pkg::REG_H4_H5, 64'hffffffff_00000001);
      write_reg(hpm_pkg::REG_H8, 64'hffffffff_80000000);
      write_reg(hpm_pkg::REG_LENGTH, 64'h7fffffff);
      write_reg(hpm_pkg::REG_WIDTH, 64'h7fffffff);
      write_reg(hpm_pkg::REG_MARGIN, 64'h7fffffff);
      for (int i = 0; i < 6; i++) send_point(random_point(), 1'b0);
      wait_drained();

      // Random phases with several register settings.
      for (int ph = 0; ph < 8; ph++) begin
         random_setting(ph == 3);
         if (ph == 2) hold_rsp = 1'b1;
         for (int i = 0; i < RANDOM_BEATS / 8; i++) send_point(random_point(), 1'b1);
         wait_drained();
      end

      tmo = 0;
      while (expected_points.size() != 0 && tmo < 100000) begin
         @(posedge clock);
         tmo++;
      end
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_points.size() == 0) begin
         $display("homography_point_mapper: match");
      end else begin
         $display("homography_point_mapper: mismatch");
      end
      $finish;
   end

endmodule

### homography_point_mapper.f
+incdir+rtl
rtl/hpm_pkg.sv
rtl/hpm_front.sv
rtl/hpm_div_step.sv
rtl/hpm_back.sv
rtl/homography_point_mapper.sv
sim/homography_point_mapper_test.sv
